// ===== design/elr_pkg.sv =====
// Shared types, constants and helpers for the echoing line editor ring.
`default_nettype none
package elr_pkg;

  // Ring geometry
  localparam int unsigned RING_LINES = 4;
  localparam int unsigned LINE_BYTES = 64;
  localparam int unsigned LINE_W     = $clog2(RING_LINES);
  localparam int unsigned LEN_W      = $clog2(LINE_BYTES);

  // Request queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef logic [LINE_W-1:0] line_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Longest line that fits, one slot kept free
  localparam len_t MAX_LEN = len_t'(LINE_BYTES - 1);

  // Character codes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;

  // Operation decoded by the front
  typedef enum logic [1:0] {
    OP_POP,
    OP_NEWLINE,
    OP_ERASE,
    OP_CHAR
  } op_e;

  // Result kinds
  typedef enum logic [2:0] {
    K_ECHO  = 3'd0,
    K_LINE  = 3'd1,
    K_EMPTY = 3'd2,
    K_NONE  = 3'd3,
    K_OVF   = 3'd4
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_BS,
    S_CRLF,
    S_POP_RD,
    S_POP_OUT
  } back_state_e;

  // One decoded request
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } q_item_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Advance a ring index with wrap
  function automatic line_t next_line(input line_t l);
    line_t r;
    if (l == line_t'(RING_LINES - 1)) begin
      r = '0;
    end else begin
      r = l + line_t'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/elr_front.sv =====
// Front end: accepts input requests, classifies them and feeds the queue.
`default_nettype none
module elr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  wire logic              s_axis_tuser,   // [0] action
  input  wire elr_pkg::q_stat_t  q_stat_i,
  output logic                   q_push_o,
  output elr_pkg::q_item_t       q_item_o
);

  logic             valid_q, valid_d;
  elr_pkg::q_item_t item_q;
  elr_pkg::q_item_t item_dec;
  logic             accept;

  // Classify the incoming request
  always_comb begin
    item_dec.ch = s_axis_tdata;
    if (s_axis_tuser) begin
      item_dec.op = elr_pkg::OP_POP;
    end else begin
      unique case (s_axis_tdata) inside
        elr_pkg::CH_CR, elr_pkg::CH_LF: item_dec.op = elr_pkg::OP_NEWLINE;
        elr_pkg::CH_BS:                 item_dec.op = elr_pkg::OP_ERASE;
        default:                        item_dec.op = elr_pkg::OP_CHAR;
      endcase
    end
  end

  // Push the held request as soon as the queue has room
  assign q_push_o      = valid_q && !q_stat_i.full;
  assign q_item_o      = item_q;
  assign s_axis_tready = !valid_q || !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the decoded request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_dec;
    end
  end

endmodule
`default_nettype wire

// ===== design/elr_queue.sv =====
// Short request queue between front end and back end.
`default_nettype none
module elr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire elr_pkg::q_item_t  push_item_i,
  input  wire logic              pop_i,
  output elr_pkg::q_item_t       pop_item_o,
  output elr_pkg::q_stat_t       stat_o
);

  elr_pkg::q_item_t                  slot_q [elr_pkg::Q_DEPTH];
  logic [elr_pkg::Q_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [elr_pkg::Q_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [elr_pkg::Q_PTR_W:0]         cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (elr_pkg::Q_PTR_W+1)'(elr_pkg::Q_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_item_o   = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == elr_pkg::Q_PTR_W'(elr_pkg::Q_DEPTH - 1)) ? '0
               : wr_ptr_q + elr_pkg::Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == elr_pkg::Q_PTR_W'(elr_pkg::Q_DEPTH - 1)) ? '0
               : rd_ptr_q + elr_pkg::Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (elr_pkg::Q_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (elr_pkg::Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/elr_back.sv =====
// Back end: edits the line ring, streams committed lines and emits results.
`default_nettype none
module elr_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire elr_pkg::q_stat_t  q_stat_i,
  input  wire elr_pkg::q_item_t  q_item_i,
  output logic                   q_pop_o,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,  // [7:0] out_byte, [8] lines_pending
  output logic [2:0]             m_axis_tuser,  // [2:0] kind
  output logic                   m_axis_tlast
);

  elr_pkg::back_state_e state_q, state_d;
  logic [1:0]           step_q;
  elr_pkg::len_t        idx_q;
  elr_pkg::line_t       pop_line_q;
  elr_pkg::len_t        pop_len_q;
  elr_pkg::kind_e       one_kind_q;
  logic [7:0]           one_byte_q;
  logic                 ovf_q;
  elr_pkg::line_t       wl_q, rl_q;
  elr_pkg::len_t        cur_len_q;
  elr_pkg::len_t        len_q [elr_pkg::RING_LINES];
  logic [7:0]           rd_q;
  logic [7:0]           store_q [elr_pkg::RING_LINES][elr_pkg::LINE_BYTES];

  // Output register
  logic                 m_valid_q;
  elr_pkg::kind_e       m_kind_q;
  logic [7:0]           m_byte_q;
  logic                 m_last_q;
  logic                 m_pend_q;

  logic                 fetch;
  logic                 emit_ok;
  logic                 res_fire;
  elr_pkg::kind_e       res_kind;
  logic [7:0]           res_byte;
  logic                 res_last;
  logic                 pop_end;
  elr_pkg::line_t       wl_next;
  elr_pkg::len_t        rl_len;
  logic                 char_fits;

  assign fetch     = (state_q == elr_pkg::S_IDLE) && !q_stat_i.empty;
  assign q_pop_o   = fetch;
  assign emit_ok   = !m_valid_q || m_axis_tready;
  assign pop_end   = (idx_q == pop_len_q - elr_pkg::len_t'(1));
  assign wl_next   = elr_pkg::next_line(wl_q);
  assign rl_len    = len_q[rl_q];
  assign char_fits = (cur_len_q != elr_pkg::MAX_LEN);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      elr_pkg::S_IDLE: begin
        if (fetch) begin
          unique case (q_item_i.op)
            elr_pkg::OP_POP: begin
              if (wl_q == rl_q || rl_len == '0) begin
                state_d = elr_pkg::S_ONE;
              end else begin
                state_d = elr_pkg::S_POP_RD;
              end
            end
            elr_pkg::OP_NEWLINE: state_d = elr_pkg::S_CRLF;
            elr_pkg::OP_ERASE: begin
              state_d = (cur_len_q != '0) ? elr_pkg::S_BS : elr_pkg::S_IDLE;
            end
            default: state_d = elr_pkg::S_ONE;
          endcase
        end
      end
      elr_pkg::S_ONE: begin
        if (emit_ok) state_d = elr_pkg::S_IDLE;
      end
      elr_pkg::S_BS: begin
        if (emit_ok && step_q == 2'd2) state_d = elr_pkg::S_IDLE;
      end
      elr_pkg::S_CRLF: begin
        if (emit_ok && (step_q == 2'd2 || (step_q == 2'd1 && !ovf_q))) begin
          state_d = elr_pkg::S_IDLE;
        end
      end
      elr_pkg::S_POP_RD: state_d = elr_pkg::S_POP_OUT;
      elr_pkg::S_POP_OUT: begin
        if (emit_ok) state_d = pop_end ? elr_pkg::S_IDLE : elr_pkg::S_POP_RD;
      end
      default: state_d = elr_pkg::S_IDLE;
    endcase
  end

  // Select the result for the current step
  always_comb begin
    res_fire = 1'b0;
    res_kind = elr_pkg::K_ECHO;
    res_byte = 8'h00;
    res_last = 1'b0;
    unique case (state_q)
      elr_pkg::S_ONE: begin
        res_fire = emit_ok;
        res_kind = one_kind_q;
        res_byte = one_byte_q;
        res_last = 1'b1;
      end
      elr_pkg::S_BS: begin
        res_fire = emit_ok;
        res_byte = (step_q == 2'd1) ? elr_pkg::CH_SP : elr_pkg::CH_BS;
        res_last = (step_q == 2'd2);
      end
      elr_pkg::S_CRLF: begin
        res_fire = emit_ok;
        if (step_q == 2'd0) begin
          res_byte = elr_pkg::CH_CR;
        end else if (step_q == 2'd1) begin
          res_byte = elr_pkg::CH_LF;
          res_last = !ovf_q;
        end else begin
          res_kind = elr_pkg::K_OVF;
          res_last = 1'b1;
        end
      end
      elr_pkg::S_POP_OUT: begin
        res_fire = emit_ok;
        res_kind = elr_pkg::K_LINE;
        res_byte = rd_q;
        res_last = pop_end;
      end
      default: ;
    endcase
  end

  // Sequencer and ring control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= elr_pkg::S_IDLE;
      step_q    <= '0;
      idx_q     <= '0;
      wl_q      <= '0;
      rl_q      <= '0;
      cur_len_q <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < elr_pkg::RING_LINES; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fetch) begin
        step_q <= '0;
        idx_q  <= '0;
        unique case (q_item_i.op)
          elr_pkg::OP_POP: begin
            if (wl_q != rl_q) begin
              rl_q <= elr_pkg::next_line(rl_q);
            end
          end
          elr_pkg::OP_NEWLINE: begin
            cur_len_q <= '0;
            if (wl_next == rl_q) begin
              ovf_q <= 1'b1;
            end else begin
              ovf_q      <= 1'b0;
              len_q[wl_q] <= cur_len_q;
              wl_q       <= wl_next;
            end
          end
          elr_pkg::OP_ERASE: begin
            if (cur_len_q != '0) begin
              cur_len_q <= cur_len_q - elr_pkg::len_t'(1);
            end
          end
          default: begin
            if (char_fits) begin
              cur_len_q <= cur_len_q + elr_pkg::len_t'(1);
            end
          end
        endcase
      end else if (res_fire) begin
        step_q <= step_q + 2'd1;
        if (state_q == elr_pkg::S_POP_OUT) begin
          idx_q <= idx_q + elr_pkg::len_t'(1);
        end
      end
      if (res_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Latch per-request payload
  always_ff @(posedge clk_i) begin
    if (fetch) begin
      one_byte_q <= 8'h00;
      if (q_item_i.op == elr_pkg::OP_POP) begin
        pop_line_q <= rl_q;
        pop_len_q  <= rl_len;
        one_kind_q <= (wl_q == rl_q) ? elr_pkg::K_NONE : elr_pkg::K_EMPTY;
      end else if (char_fits) begin
        one_kind_q <= elr_pkg::K_ECHO;
        one_byte_q <= q_item_i.ch;
      end else begin
        one_kind_q <= elr_pkg::K_OVF;
      end
    end
    if (res_fire) begin
      m_kind_q <= res_kind;
      m_byte_q <= res_byte;
      m_last_q <= res_last;
      m_pend_q <= (wl_q != rl_q);
    end
  end

  // Line store: write appended characters, read one byte per pop step
  always_ff @(posedge clk_i) begin
    if (fetch && q_item_i.op == elr_pkg::OP_CHAR && char_fits) begin
      store_q[wl_q][cur_len_q] <= q_item_i.ch;
    end
    if (state_q == elr_pkg::S_POP_RD) begin
      rd_q <= store_q[pop_line_q][idx_q];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_pend_q, m_byte_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  // The line being edited never exceeds its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= elr_pkg::MAX_LEN)
    else $error("current line length beyond capacity");

  // A streamed line is never empty and the index stays inside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == elr_pkg::S_POP_RD || state_q == elr_pkg::S_POP_OUT)
      |-> (pop_len_q != '0 && idx_q < pop_len_q))
    else $error("pop index outside committed line");

  // A pop with lines pending advances the read line by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fetch && q_item_i.op == elr_pkg::OP_POP && wl_q != rl_q)
      |=> (rl_q == elr_pkg::next_line($past(rl_q))))
    else $error("read line did not advance on pop");

  // A new request is taken only once the previous results are all issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_last |=> state_q == elr_pkg::S_IDLE)
    else $error("sequencer busy after final result");
`endif

endmodule
`default_nettype wire

// ===== design/echoing_line_editor_ring_unit.sv =====
// Echoing line editor ring: top level joining front end, queue and back end.
// A request passes through the front-end holding register and the queue to the back end,
// whose results leave through a registered output; a line pop first reads the store.
// A received byte yields up to 3 results; the back end takes the next request only after
// the last result of the current one is issued. A line pop reads each stored byte in turn.
// Reset (rst_ni low, asynchronous) empties the ring and the queue; line storage is not cleared.
`default_nettype none
module echoing_line_editor_ring_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] lines_pending
  output logic [2:0]       m_axis_tuser,   // [2:0] kind
  output logic             m_axis_tlast
);

  elr_pkg::q_stat_t q_stat;
  elr_pkg::q_item_t push_item;
  elr_pkg::q_item_t pop_item;
  logic             q_push;
  logic             q_pop;

  elr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  elr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  elr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the echoing line editor ring unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import elr_pkg::*;

  localparam logic ACT_RX  = 1'b0;
  localparam logic ACT_POP = 1'b1;
  localparam int   RANDOM_KEYS  = 500;
  localparam int   LONG_HOLD    = 400;
  localparam int   HOLD_AFTER   = 150;
  localparam int   DRAIN_CYCLES = 32;
  localparam int   STALL_LIMIT  = 3000;

  // One keystroke or pop request toward the block
  typedef struct packed {
    logic       act;
    logic [7:0] ch;
  } keystroke_t;

  // One terminal output item as the block should emit it
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic       pend;
  } term_out_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        s_axis_tuser  = 1'b0;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] lines_pending
  logic [2:0]  m_axis_tuser;           // [2:0] kind
  logic        m_axis_tlast;

  echoing_line_editor_ring_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the ring of line buffers
  logic [7:0] line_mem [RING_LINES][LINE_BYTES];
  len_t       line_len [RING_LINES];
  line_t      wr_line;
  line_t      rd_line;

  keystroke_t keystroke_q[$];
  term_out_t  term_out_q[$];
  term_out_t  want;
  int         key_count   = 0;
  int         mismatch_cnt = 0;
  int         checked_cnt = 0;
  int         tx_gap      = 0;
  int         rx_stall    = 0;
  int         hold_left   = 0;
  bit         hold_done   = 1'b0;
  bit         no_idle     = 1'b0;
  int         phase_cnt   = 0;
  int         idle_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Apply one request to the shadow ring and queue the output it causes
  task automatic edit_and_emit(input logic act, input logic [7:0] ch);
    term_out_t batch[$];
    line_t     nxt;
    len_t      cur_len;
    cur_len = line_len[wr_line];
    nxt = line_t'((int'(wr_line) + 1) % RING_LINES);
    if (act == ACT_POP) begin
      if (wr_line == rd_line) begin
        batch.push_back('{kind: K_NONE, data: 8'h00, last: 1'b0, pend: 1'b0});
      end else begin
        if (line_len[rd_line] == '0) begin
          batch.push_back('{kind: K_EMPTY, data: 8'h00, last: 1'b0, pend: 1'b0});
        end
        for (int i = 0; i < int'(line_len[rd_line]); i++) begin
          batch.push_back('{kind: K_LINE, data: line_mem[rd_line][i], last: 1'b0,
                            pend: 1'b0});
        end
        rd_line = line_t'((int'(rd_line) + 1) % RING_LINES);
      end
    end else if (ch == CH_CR || ch == CH_LF) begin
      batch.push_back('{kind: K_ECHO, data: CH_CR, last: 1'b0, pend: 1'b0});
      batch.push_back('{kind: K_ECHO, data: CH_LF, last: 1'b0, pend: 1'b0});
      // Ring full: drop the commit and empty the line in place
      if (nxt == rd_line) begin
        line_len[wr_line] = '0;
        batch.push_back('{kind: K_OVF, data: 8'h00, last: 1'b0, pend: 1'b0});
      end else begin
        wr_line = nxt;
        line_len[nxt] = '0;
      end
    end else if (ch == CH_BS) begin
      if (cur_len != '0) begin
        line_len[wr_line] = cur_len - len_t'(1);
        batch.push_back('{kind: K_ECHO, data: CH_BS, last: 1'b0, pend: 1'b0});
        batch.push_back('{kind: K_ECHO, data: CH_SP, last: 1'b0, pend: 1'b0});
        batch.push_back('{kind: K_ECHO, data: CH_BS, last: 1'b0, pend: 1'b0});
      end
    end else if (cur_len >= MAX_LEN) begin
      batch.push_back('{kind: K_OVF, data: 8'h00, last: 1'b0, pend: 1'b0});
    end else begin
      line_mem[wr_line][cur_len] = ch;
      line_len[wr_line] = cur_len + len_t'(1);
      batch.push_back('{kind: K_ECHO, data: ch, last: 1'b0, pend: 1'b0});
    end
    // Stamp pending flag and last mark, then hand over
    foreach (batch[i]) begin
      batch[i].pend = (wr_line != rd_line);
      batch[i].last = (i == batch.size() - 1);
      term_out_q.push_back(batch[i]);
    end
  endtask

  task automatic queue_key(input logic act, input logic [7:0] ch);
    keystroke_q.push_back('{act: act, ch: ch});
    key_count++;
  endtask

  // Random byte that is neither a line end nor a backspace
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == CH_CR || c == CH_LF || c == CH_BS);
    return c;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Toggle stretches with no idling on either side
  always @(posedge clk_i) begin
    phase_cnt++;
    if (phase_cnt % 200 == 0) begin
      no_idle <= ($urandom_range(0, 2) == 0);
    end
  end

  // Sender: offer queued requests, update the shadow ring on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        edit_and_emit(s_axis_tuser, s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (keystroke_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= keystroke_q[0].act;
          s_axis_tdata  <= keystroke_q[0].ch;
          void'(keystroke_q.pop_front());
          if (!no_idle && $urandom_range(0, 2) == 0) begin
            tx_gap = pick_gap();
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall at random, hold off once for long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_cnt++;
        if (term_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                    m_axis_tuser, m_axis_tdata[7:0]));
        end else begin
          want = term_out_q.pop_front();
          if (m_axis_tuser !== want.kind) begin
            report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
          end
          if (m_axis_tdata[7:0] !== want.data) begin
            report_mismatch($sformatf("byte %02h, want %02h", m_axis_tdata[7:0],
                                      want.data));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
          end
          if (m_axis_tdata[8] !== want.pend) begin
            report_mismatch($sformatf("lines_pending %b, want %b", m_axis_tdata[8],
                                      want.pend));
          end
        end
      end
      if (!hold_done && checked_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
          rx_stall = pick_gap();
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    bit is_long;
    foreach (line_len[i]) begin
      line_len[i] = '0;
    end
    wr_line = '0;
    rd_line = '0;

    // Directed: empty ring, erase on empty line, byte extremes, commits
    queue_key(ACT_POP, 8'hFF);
    queue_key(ACT_RX,  CH_BS);
    queue_key(ACT_RX,  8'h00);
    queue_key(ACT_RX,  8'hFF);
    queue_key(ACT_RX,  CH_BS);
    queue_key(ACT_RX,  8'h41);
    queue_key(ACT_RX,  CH_CR);
    queue_key(ACT_RX,  CH_LF);
    queue_key(ACT_RX,  8'h80);
    queue_key(ACT_RX,  8'h7F);
    queue_key(ACT_RX,  CH_SP);
    queue_key(ACT_RX,  CH_CR);
    // Ring now full: this commit is discarded
    queue_key(ACT_RX,  8'h55);
    queue_key(ACT_RX,  CH_LF);
    // Drain: line, empty line, line, nothing left
    queue_key(ACT_POP, 8'h00);
    queue_key(ACT_POP, CH_CR);
    queue_key(ACT_POP, 8'hAA);
    queue_key(ACT_POP, 8'h55);
    queue_key(ACT_RX,  8'hAA);
    queue_key(ACT_RX,  CH_LF);
    queue_key(ACT_POP, CH_BS);

    // Random: typed lines with edits, pops, and some noise
    is_long = 1'b1;
    while (key_count < RANDOM_KEYS) begin
      pick = $urandom_range(0, 99);
      if (is_long || pick < 50) begin
        if (!is_long && $urandom_range(0, 19) == 0) begin
          is_long = 1'b1;
        end
        len = is_long ? $urandom_range(64, 70) : $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          if (!is_long && $urandom_range(0, 6) == 0) begin
            queue_key(ACT_RX, CH_BS);
          end else begin
            queue_key(ACT_RX, plain_char());
          end
        end
        queue_key(ACT_RX, ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
        is_long = 1'b0;
      end else if (pick < 85) begin
        queue_key(ACT_POP, 8'($urandom));
      end else begin
        queue_key(1'($urandom), 8'($urandom));
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every result has come back
    do begin
      @(negedge clk_i);
    end while (keystroke_q.size() != 0 || s_axis_tvalid || term_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
